>>> design/stereo_exact_timestamp_pairer_unit_defines.svh
`ifndef STEREO_EXACT_TIMESTAMP_PAIRER_UNIT_DEFINES_SVH
`define STEREO_EXACT_TIMESTAMP_PAIRER_UNIT_DEFINES_SVH

// check cons in the same cycle as ante
`define STETP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define STETP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/stetp_pkg.sv
`default_nettype none

package stetp_pkg;

   localparam int unsigned TABLE_DEPTH = 256;
   localparam int unsigned LIMIT_W = 9;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd240;

   typedef enum logic [1:0] {
      ST_PAIRED    = 2'd0,
      ST_PENDING   = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_REJECTED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_CHECK  = 3'd1,
      S_SCAN   = 3'd2,
      S_DECIDE = 3'd3,
      S_DONE   = 3'd4,
      S_CLEAR  = 3'd5,
      S_EVICT  = 3'd6
   } state_type;

   typedef struct packed {
      logic        kind;
      logic [63:0] frame_seq;
      logic [63:0] sdk_stamp;
      logic [63:0] payload_stamp;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] pair_stamp;
      logic [63:0] left_frame_seq;
      logic [63:0] right_frame_seq;
      logic        evicted;
      logic [63:0] evicted_stamp;
      logic [63:0] evicted_seq;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] stamp;
      logic [63:0] seq;
   } entry_type;

   typedef struct packed {
      logic hit_oth;
      logic hit_own;
      logic free_found;
      logic min_found;
   } scan_flags_type;

endpackage

`default_nettype wire

>>> design/stereo_exact_timestamp_pairer_unit.sv
`default_nettype none

// Pairs left and right camera frame words by exact capture stamp and returns one
// result word per frame. After reset the block clears both side tables, one entry
// per cycle, through all TABLE_DEPTH + 1 entries, and takes no frame meanwhile. A
// frame passes from acceptance to its result through a check state, a scan of all
// TABLE_DEPTH + 1 entries of both side tables through one registered read
// port each (one entry per cycle), an update state and the load of the output
// register. A stored frame that pushes out an older entry passes through an
// evict state to clear that entry. Frames rejected for a missing stamp or dropped
// as duplicates go straight from the check state to the output register.
// A new frame is taken only while the block is idle, from the cycle after the
// previous result is loaded; a finished result waits in the output register, and
// only the final load of the next frame stalls behind it. Write pending_limit
// through the csr port only while no frame is in flight.
module stereo_exact_timestamp_pairer_unit #(
   parameter int unsigned TABLE_DEPTH = stetp_pkg::TABLE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire stetp_pkg::req_type    req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output stetp_pkg::rsp_type         rsp_word,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [stetp_pkg::LIMIT_W-1:0] csr_word
);

   localparam int unsigned SLOTS = TABLE_DEPTH + 1;
   localparam int unsigned AW = $clog2(SLOTS);
   localparam int unsigned CW = $clog2(SLOTS + 1);
   localparam int unsigned LW = (CW > stetp_pkg::LIMIT_W) ? CW : stetp_pkg::LIMIT_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
   localparam logic [LW-1:0] DEPTH_LIM = LW'(TABLE_DEPTH);
   localparam logic [LW-1:0] ONE_LIM = LW'(1);

   stetp_pkg::state_type state_ff, state_in;
   stetp_pkg::req_type   item_ff, item_in;
   logic [stetp_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [63:0]          last_ff [2];
   logic [63:0]          last_in [2];
   logic [CW-1:0]        cnt_ff [2];
   logic [CW-1:0]        cnt_in [2];
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 issue_ff, issue_in;
   logic                 chk_ff, chk_in;
   logic [AW-1:0]        chk_idx_ff, chk_idx_in;
   stetp_pkg::rsp_type   res_ff, res_in;
   stetp_pkg::rsp_type   rsp_word_ff, rsp_word_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 own_side;
   logic [63:0]          stamp;
   logic                 dup;
   logic [LW-1:0]        limit_ext;
   logic [LW-1:0]        limit_eff;
   logic [LW-1:0]        cnt_new;
   logic                 over;
   logic                 evict_new;
   logic [AW-1:0]        w_slot;
   logic                 left_we;
   logic                 right_we;
   logic [AW-1:0]        wr_addr;
   logic                 out_free;

   stetp_pkg::entry_type      left_rd, right_rd, own_rd, oth_rd, wr_entry;
   stetp_pkg::scan_flags_type flags;
   logic [AW-1:0]             oth_slot, own_slot, free_slot, min_slot;
   logic [63:0]               oth_seq, min_stamp, min_seq;

   assign own_side  = item_ff.kind;
   assign stamp     = (item_ff.sdk_stamp != '0) ? item_ff.sdk_stamp : item_ff.payload_stamp;
   assign dup       = (item_ff.frame_seq != '0) && (item_ff.frame_seq <= last_ff[own_side]);
   assign limit_ext = LW'(limit_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign own_rd    = own_side ? right_rd : left_rd;
   assign oth_rd    = own_side ? left_rd : right_rd;
   assign w_slot    = flags.hit_own ? own_slot : free_slot;
   assign cnt_new   = LW'(cnt_ff[own_side]) + (flags.hit_own ? LW'(0) : ONE_LIM);
   assign over      = cnt_new > limit_eff;
   assign evict_new = !flags.min_found || (stamp <= min_stamp);

   always_comb begin
      if (limit_ext == '0) begin
         limit_eff = ONE_LIM;
      end else if (limit_ext > DEPTH_LIM) begin
         limit_eff = DEPTH_LIM;
      end else begin
         limit_eff = limit_ext;
      end
   end

   always_comb begin
      left_we  = 1'b0;
      right_we = 1'b0;
      wr_addr  = w_slot;
      wr_entry = '0;
      unique case (state_ff)
         stetp_pkg::S_CLEAR: begin
            left_we  = 1'b1;
            right_we = 1'b1;
            wr_addr  = addr_ff;
         end
         stetp_pkg::S_DECIDE: begin
            if (flags.hit_oth) begin
               left_we  = own_side;
               right_we = !own_side;
               wr_addr  = oth_slot;
            end else begin
               left_we  = !own_side;
               right_we = own_side;
               if (!(over && evict_new)) begin
                  wr_entry.valid = 1'b1;
                  wr_entry.stamp = stamp;
                  wr_entry.seq   = item_ff.frame_seq;
               end
            end
         end
         stetp_pkg::S_EVICT: begin
            left_we  = !own_side;
            right_we = own_side;
            wr_addr  = min_slot;
         end
         default: begin
            wr_addr = w_slot;
         end
      endcase
   end

   stetp_table #(.SLOTS(SLOTS)) u_left_table (
      .clock   (clock),
      .wr_en   (left_we),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (left_rd)
   );

   stetp_table #(.SLOTS(SLOTS)) u_right_table (
      .clock   (clock),
      .wr_en   (right_we),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (right_rd)
   );

   stetp_scan #(.SLOTS(SLOTS)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .clear     (state_ff == stetp_pkg::S_CHECK),
      .chk       (chk_ff),
      .chk_idx   (chk_idx_ff),
      .key       (stamp),
      .oth_entry (oth_rd),
      .oth_valid (oth_rd.valid),
      .own_entry (own_rd),
      .own_valid (own_rd.valid),
      .flags     (flags),
      .oth_slot  (oth_slot),
      .oth_seq   (oth_seq),
      .own_slot  (own_slot),
      .free_slot (free_slot),
      .min_slot  (min_slot),
      .min_stamp (min_stamp),
      .min_seq   (min_seq)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stetp_pkg::S_CLEAR: begin
            if (addr_ff == LAST_SLOT) begin
               state_in = stetp_pkg::S_IDLE;
            end
         end
         stetp_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = stetp_pkg::S_CHECK;
            end
         end
         stetp_pkg::S_CHECK: begin
            if ((stamp == '0) || dup) begin
               state_in = stetp_pkg::S_DONE;
            end else begin
               state_in = stetp_pkg::S_SCAN;
            end
         end
         stetp_pkg::S_SCAN: begin
            if (chk_ff && (chk_idx_ff == LAST_SLOT)) begin
               state_in = stetp_pkg::S_DECIDE;
            end
         end
         stetp_pkg::S_DECIDE: begin
            if (!flags.hit_oth && over && !evict_new) begin
               state_in = stetp_pkg::S_EVICT;
            end else begin
               state_in = stetp_pkg::S_DONE;
            end
         end
         stetp_pkg::S_EVICT: begin
            state_in = stetp_pkg::S_DONE;
         end
         stetp_pkg::S_DONE: begin
            if (out_free) begin
               state_in = stetp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = stetp_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      item_in      = item_ff;
      limit_in     = csr_valid ? csr_word : limit_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      issue_in     = 1'b0;
      chk_in       = 1'b0;
      chk_idx_in   = chk_idx_ff;
      res_in       = res_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         stetp_pkg::S_CLEAR: begin
            addr_in = addr_ff + AW'(1);
         end
         stetp_pkg::S_IDLE: begin
            if (req_valid) begin
               item_in = req_word;
            end
         end
         stetp_pkg::S_CHECK: begin
            res_in            = '0;
            res_in.pair_stamp = stamp;
            addr_in           = '0;
            if (stamp == '0) begin
               res_in.status = stetp_pkg::ST_REJECTED;
            end else if (dup) begin
               res_in.status = stetp_pkg::ST_DUPLICATE;
            end else begin
               res_in.status     = stetp_pkg::ST_PENDING;
               last_in[own_side] = item_ff.frame_seq;
               issue_in          = 1'b1;
            end
         end
         stetp_pkg::S_SCAN: begin
            if (issue_ff) begin
               chk_in     = 1'b1;
               chk_idx_in = addr_ff;
               if (addr_ff != LAST_SLOT) begin
                  issue_in = 1'b1;
                  addr_in  = addr_ff + AW'(1);
               end
            end
         end
         stetp_pkg::S_DECIDE: begin
            if (flags.hit_oth) begin
               res_in.status          = stetp_pkg::ST_PAIRED;
               res_in.left_frame_seq  = own_side ? oth_seq : item_ff.frame_seq;
               res_in.right_frame_seq = own_side ? item_ff.frame_seq : oth_seq;
               cnt_in[~own_side]      = cnt_ff[~own_side] - CW'(1);
            end else begin
               cnt_in[own_side] = CW'(cnt_new - (over ? ONE_LIM : LW'(0)));
               if (over) begin
                  res_in.evicted = 1'b1;
                  if (evict_new) begin
                     res_in.evicted_stamp = stamp;
                     res_in.evicted_seq   = item_ff.frame_seq;
                  end else begin
                     res_in.evicted_stamp = min_stamp;
                     res_in.evicted_seq   = min_seq;
                  end
               end
            end
         end
         stetp_pkg::S_EVICT: begin
            issue_in = 1'b0;
         end
         stetp_pkg::S_DONE: begin
            if (out_free) begin
               rsp_word_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            issue_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stetp_pkg::S_CLEAR;
         limit_ff     <= stetp_pkg::LIMIT_RESET;
         last_ff[0]   <= '0;
         last_ff[1]   <= '0;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         addr_ff      <= '0;
         issue_ff     <= 1'b0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         addr_ff      <= addr_in;
         issue_ff     <= issue_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      chk_idx_ff  <= chk_idx_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_ready = (state_ff == stetp_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

>>> design/stetp_table.sv
`default_nettype none

module stetp_table #(
   parameter int unsigned SLOTS = stetp_pkg::TABLE_DEPTH + 1,
   localparam int unsigned AW = $clog2(SLOTS)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire stetp_pkg::entry_type wr_data,
   input  wire logic [AW-1:0]        rd_addr,
   output stetp_pkg::entry_type      rd_data
);

   stetp_pkg::entry_type mem_ff [SLOTS];
   stetp_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/stetp_scan.sv
`default_nettype none

module stetp_scan #(
   parameter int unsigned SLOTS = stetp_pkg::TABLE_DEPTH + 1,
   localparam int unsigned AW = $clog2(SLOTS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire logic                  chk,
   input  wire logic [AW-1:0]         chk_idx,
   input  wire logic [63:0]           key,
   input  wire stetp_pkg::entry_type  oth_entry,
   input  wire logic                  oth_valid,
   input  wire stetp_pkg::entry_type  own_entry,
   input  wire logic                  own_valid,
   output stetp_pkg::scan_flags_type  flags,
   output logic [AW-1:0]              oth_slot,
   output logic [63:0]                oth_seq,
   output logic [AW-1:0]              own_slot,
   output logic [AW-1:0]              free_slot,
   output logic [AW-1:0]              min_slot,
   output logic [63:0]                min_stamp,
   output logic [63:0]                min_seq
);

   stetp_pkg::scan_flags_type flags_ff, flags_in;
   logic [AW-1:0] oth_slot_ff, oth_slot_in;
   logic [63:0]   oth_seq_ff, oth_seq_in;
   logic [AW-1:0] own_slot_ff, own_slot_in;
   logic [AW-1:0] free_slot_ff, free_slot_in;
   logic [AW-1:0] min_slot_ff, min_slot_in;
   logic [63:0]   min_stamp_ff, min_stamp_in;
   logic [63:0]   min_seq_ff, min_seq_in;

   always_comb begin
      flags_in     = flags_ff;
      oth_slot_in  = oth_slot_ff;
      oth_seq_in   = oth_seq_ff;
      own_slot_in  = own_slot_ff;
      free_slot_in = free_slot_ff;
      min_slot_in  = min_slot_ff;
      min_stamp_in = min_stamp_ff;
      min_seq_in   = min_seq_ff;
      if (clear) begin
         flags_in = '0;
      end else if (chk) begin
         if (oth_valid && (oth_entry.stamp == key) && !flags_ff.hit_oth) begin
            flags_in.hit_oth = 1'b1;
            oth_slot_in      = chk_idx;
            oth_seq_in       = oth_entry.seq;
         end
         if (own_valid && (own_entry.stamp == key)) begin
            flags_in.hit_own = 1'b1;
            own_slot_in      = chk_idx;
         end
         if (!own_valid && !flags_ff.free_found) begin
            flags_in.free_found = 1'b1;
            free_slot_in        = chk_idx;
         end
         if (own_valid && (!flags_ff.min_found || (own_entry.stamp < min_stamp_ff))) begin
            flags_in.min_found = 1'b1;
            min_slot_in        = chk_idx;
            min_stamp_in       = own_entry.stamp;
            min_seq_in         = own_entry.seq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      oth_slot_ff  <= oth_slot_in;
      oth_seq_ff   <= oth_seq_in;
      own_slot_ff  <= own_slot_in;
      free_slot_ff <= free_slot_in;
      min_slot_ff  <= min_slot_in;
      min_stamp_ff <= min_stamp_in;
      min_seq_ff   <= min_seq_in;
   end

   assign flags     = flags_ff;
   assign oth_slot  = oth_slot_ff;
   assign oth_seq   = oth_seq_ff;
   assign own_slot  = own_slot_ff;
   assign free_slot = free_slot_ff;
   assign min_slot  = min_slot_ff;
   assign min_stamp = min_stamp_ff;
   assign min_seq   = min_seq_ff;

endmodule

`default_nettype wire

>>> design/stetp_checker.sv
`default_nettype none

`include "stereo_exact_timestamp_pairer_unit_defines.svh"

module stetp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire stetp_pkg::rsp_type rsp_word
);

   `STETP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")

   `STETP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "stalled result word changed")

   `STETP_ASSERT_NOW(a_evict_only_pending, clock, reset, rsp_valid && (rsp_word.status != stetp_pkg::ST_PENDING), !rsp_word.evicted, "eviction on non pending word")

   `STETP_ASSERT_NOW(a_evict_oldest, clock, reset, rsp_valid && rsp_word.evicted, (rsp_word.evicted_stamp != '0) && (rsp_word.evicted_stamp <= rsp_word.pair_stamp), "evicted stamp above frame stamp")

   `STETP_ASSERT_NOW(a_reject_zero, clock, reset, rsp_valid && (rsp_word.status == stetp_pkg::ST_REJECTED), rsp_word.pair_stamp == '0, "rejected word with stamp")

endmodule

bind stereo_exact_timestamp_pairer_unit stetp_checker u_stetp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int SLOTS = stetp_pkg::TABLE_DEPTH + 1;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES = 20;
   localparam int DUE_DEPTH = 4;
   localparam int SIDE_LEFT = 0;
   localparam int SIDE_RIGHT = 1;
   localparam int SIDE_ANY = 2;
   localparam logic CAM_L = 1'b0;
   localparam logic CAM_R = 1'b1;
   localparam logic [63:0] Z64 = '0;
   localparam logic [63:0] ONES = '1;
   localparam logic [63:0] TOP = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALT_A = {16{4'hA}};
   localparam logic [63:0] ALT_5 = {16{4'h5}};

   typedef struct packed {
      stetp_pkg::req_type frame;
      logic               typed;
      stetp_pkg::rsp_type result;
   } frame_case_type;

   localparam int NUM_CASES = 21;
   localparam frame_case_type FRAME_CASES [0:NUM_CASES-1] = '{
      '{'{CAM_L, 64'd1, Z64, Z64}, 1'b1,
        '{stetp_pkg::ST_REJECTED, Z64, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_R, Z64, Z64, Z64}, 1'b1,
        '{stetp_pkg::ST_REJECTED, Z64, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_L, 64'd5, 64'd100, 64'd7}, 1'b1,
        '{stetp_pkg::ST_PENDING, 64'd100, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_R, 64'd9, Z64, 64'd100}, 1'b1,
        '{stetp_pkg::ST_PAIRED, 64'd100, 64'd5, 64'd9, 1'b0, Z64, Z64}},
      '{'{CAM_L, 64'd5, 64'd200, Z64}, 1'b1,
        '{stetp_pkg::ST_DUPLICATE, 64'd200, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_L, 64'd3, Z64, 64'd250}, 1'b1,
        '{stetp_pkg::ST_DUPLICATE, 64'd250, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_L, Z64, 64'd300, Z64}, 1'b1,
        '{stetp_pkg::ST_PENDING, 64'd300, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_L, 64'd1, 64'd300, 64'd9}, 1'b1,
        '{stetp_pkg::ST_PENDING, 64'd300, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_R, Z64, Z64, 64'd300}, 1'b1,
        '{stetp_pkg::ST_PAIRED, 64'd300, 64'd1, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_L, ONES, ONES, Z64}, 1'b1,
        '{stetp_pkg::ST_PENDING, ONES, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_L, ONES, 64'd5, Z64}, 1'b1,
        '{stetp_pkg::ST_DUPLICATE, 64'd5, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_L, Z64, 64'd1, Z64}, 1'b1,
        '{stetp_pkg::ST_PENDING, 64'd1, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_R, ONES, Z64, ONES}, 1'b1,
        '{stetp_pkg::ST_PAIRED, ONES, ONES, ONES, 1'b0, Z64, Z64}},
      '{'{CAM_R, 64'd1, ONES - 64'd1, Z64}, 1'b1,
        '{stetp_pkg::ST_DUPLICATE, ONES - 64'd1, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_R, Z64, TOP, Z64}, 1'b1,
        '{stetp_pkg::ST_PENDING, TOP, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_L, 64'd2, TOP, Z64}, 1'b1,
        '{stetp_pkg::ST_PAIRED, TOP, 64'd2, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_L, 64'd3, 64'd1, Z64}, 1'b0, '0},
      '{'{CAM_R, 64'd5, Z64, 64'd1}, 1'b0, '0},
      '{'{CAM_R, ALT_5, ALT_A, ALT_5}, 1'b1,
        '{stetp_pkg::ST_PENDING, ALT_A, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_L, ALT_A, ALT_5, ALT_A}, 1'b1,
        '{stetp_pkg::ST_PENDING, ALT_5, Z64, Z64, 1'b0, Z64, Z64}},
      '{'{CAM_L, Z64, Z64, ALT_A}, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   stetp_pkg::req_type req_word;
   logic rsp_valid;
   logic rsp_ready;
   stetp_pkg::rsp_type rsp_word;
   logic csr_valid;
   logic csr_ready;
   logic [stetp_pkg::LIMIT_W-1:0] csr_word;

   // pairing state as the block should hold it
   logic [63:0] held_stamp [0:1][0:SLOTS-1];
   logic [63:0] held_seq [0:1][0:SLOTS-1];
   bit held_vld [0:1][0:SLOTS-1];
   logic [63:0] prev_seq [0:1];
   logic [stetp_pkg::LIMIT_W-1:0] limit_reg = stetp_pkg::LIMIT_RESET;

   stetp_pkg::rsp_type due_buf [0:DUE_DEPTH-1];
   int due_head = 0;
   int due_tail = 0;
   int due_count = 0;
   bit typed_valid;
   stetp_pkg::rsp_type typed_rsp;
   int fault_count = 0;
   int quiet_cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   stereo_exact_timestamp_pairer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_word  (csr_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= (int'($urandom_range(99)) >= stall_pct);
   end

   function automatic stetp_pkg::rsp_type pair_frame(input stetp_pkg::req_type w);
      stetp_pkg::rsp_type r;
      int own, oth, hit, free_slot, oldest, cnt, lim;
      logic [63:0] stamp;
      r = '0;
      own = int'(w.kind);
      oth = 1 - own;
      stamp = (w.sdk_stamp != '0) ? w.sdk_stamp : w.payload_stamp;
      if (stamp == '0) begin
         r.status = stetp_pkg::ST_REJECTED;
         return r;
      end
      r.pair_stamp = stamp;
      if (w.frame_seq != '0 && w.frame_seq <= prev_seq[own]) begin
         r.status = stetp_pkg::ST_DUPLICATE;
         return r;
      end
      prev_seq[own] = w.frame_seq;
      hit = -1;
      for (int i = 0; i < SLOTS; i++)
         if (hit < 0 && held_vld[oth][i] && held_stamp[oth][i] == stamp) hit = i;
      if (hit >= 0) begin
         r.status = stetp_pkg::ST_PAIRED;
         r.left_frame_seq = (own == 0) ? w.frame_seq : held_seq[oth][hit];
         r.right_frame_seq = (own == 0) ? held_seq[oth][hit] : w.frame_seq;
         held_vld[oth][hit] = 1'b0;
         return r;
      end
      r.status = stetp_pkg::ST_PENDING;
      hit = -1;
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (held_vld[own][i]) begin
            if (hit < 0 && held_stamp[own][i] == stamp) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (hit < 0) hit = free_slot;
      held_stamp[own][hit] = stamp;
      held_seq[own][hit] = w.frame_seq;
      held_vld[own][hit] = 1'b1;
      lim = int'(limit_reg);
      if (lim < 1) lim = 1;
      if (lim > stetp_pkg::TABLE_DEPTH) lim = stetp_pkg::TABLE_DEPTH;
      cnt = 0;
      oldest = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (held_vld[own][i]) begin
            cnt++;
            if (oldest < 0 || held_stamp[own][i] < held_stamp[own][oldest]) oldest = i;
         end
      end
      if (cnt > lim) begin
         r.evicted = 1'b1;
         r.evicted_stamp = held_stamp[own][oldest];
         r.evicted_seq = held_seq[own][oldest];
         held_vld[own][oldest] = 1'b0;
      end
      return r;
   endfunction

   function automatic stetp_pkg::req_type gen_frame(input int side_mode, input int pair_pct);
      stetp_pkg::req_type w;
      int side, src, roll, n_held, pick;
      logic [63:0] last, stamp;
      w.kind = (side_mode == SIDE_ANY) ? 1'($urandom_range(1)) : 1'(side_mode);
      side = int'(w.kind);
      last = prev_seq[side];
      roll = int'($urandom_range(99));
      if (roll < 5) w.frame_seq = '0;
      else if (roll < 10)
         w.frame_seq = last - ((last > 64'd3) ? 64'($urandom_range(3)) : 64'd0);
      else if (roll < 14) w.frame_seq = {$urandom, $urandom};
      else if (last > ONES - 64'd4) w.frame_seq = '0;
      else w.frame_seq = last + 64'($urandom_range(4, 1));
      roll = int'($urandom_range(99));
      src = -1;
      if (roll >= 3 && roll < 3 + pair_pct) src = 1 - side;
      else if (roll >= 3 + pair_pct && roll < 11 + pair_pct) src = side;
      n_held = 0;
      if (src >= 0)
         for (int i = 0; i < SLOTS; i++)
            if (held_vld[src][i]) n_held++;
      if (roll < 3) begin
         stamp = '0;
      end else if (n_held != 0) begin
         pick = int'($urandom_range(n_held - 1));
         stamp = '0;
         for (int i = 0; i < SLOTS; i++)
            if (held_vld[src][i]) begin
               if (pick == 0) stamp = held_stamp[src][i];
               pick--;
            end
      end else begin
         stamp = {$urandom, $urandom};
         if (stamp == '0) stamp = 64'd1;
      end
      if (stamp == '0) begin
         w.sdk_stamp = '0;
         w.payload_stamp = '0;
      end else if ($urandom_range(1) != 0) begin
         w.sdk_stamp = stamp;
         w.payload_stamp = {$urandom, $urandom};
      end else begin
         w.sdk_stamp = '0;
         w.payload_stamp = stamp;
      end
      return w;
   endfunction

   task automatic flag_fault(input string what, input stetp_pkg::rsp_type e,
                             input stetp_pkg::rsp_type a);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%s: expected st=%0d stamp=%h l=%h r=%h ev=%0b %h %h", what,
                  e.status, e.pair_stamp, e.left_frame_seq, e.right_frame_seq, e.evicted,
                  e.evicted_stamp, e.evicted_seq);
         $display("   actual   st=%0d stamp=%h l=%h r=%h ev=%0b %h %h",
                  a.status, a.pair_stamp, a.left_frame_seq, a.right_frame_seq, a.evicted,
                  a.evicted_stamp, a.evicted_seq);
      end
   endtask

   always @(posedge clock) begin
      stetp_pkg::rsp_type due;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_count == 0) begin
               flag_fault("result word with nothing pending", '0, rsp_word);
            end else begin
               due = due_buf[due_head];
               due_head = (due_head + 1) % DUE_DEPTH;
               due_count--;
               if (rsp_word.status !== due.status || rsp_word.pair_stamp !== due.pair_stamp
                   || rsp_word.left_frame_seq !== due.left_frame_seq
                   || rsp_word.right_frame_seq !== due.right_frame_seq
                   || rsp_word.evicted !== due.evicted
                   || rsp_word.evicted_stamp !== due.evicted_stamp
                   || rsp_word.evicted_seq !== due.evicted_seq)
                  flag_fault("result word mismatch", due, rsp_word);
            end
         end
         if (req_valid && req_ready) begin
            due = pair_frame(req_word);
            if (typed_valid) due = typed_rsp;
            due_buf[due_tail] = due;
            due_tail = (due_tail + 1) % DUE_DEPTH;
            due_count++;
         end
         if (csr_valid && csr_ready) limit_reg = csr_word;
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("stereo_exact_timestamp_pairer_unit regression: fail");
         $finish;
      end
   end

   task automatic send_frame(input stetp_pkg::req_type w, input logic typed,
                             input stetp_pkg::rsp_type r);
      while (int'($urandom_range(99)) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_word = w;
      typed_valid = typed;
      typed_rsp = r;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // hold off the sender until every result word is back
   task automatic settle();
      req_valid = 1'b0;
      while (due_count != 0) @(negedge clock);
   endtask

   task automatic write_limit(input logic [stetp_pkg::LIMIT_W-1:0] v);
      csr_word = v;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_phase(input logic write_cfg,
                            input logic [stetp_pkg::LIMIT_W-1:0] lim,
                            input int n_frames, input int idle, input int stall,
                            input int side_mode, input int pair_pct);
      settle();
      idle_pct = idle;
      stall_pct = stall;
      if (write_cfg) write_limit(lim);
      for (int k = 0; k < n_frames; k++) begin
         if (k % 40 == 39) settle();
         send_frame(gen_frame(side_mode, pair_pct), 1'b0, '0);
      end
   endtask

   initial begin
      for (int s = 0; s < 2; s++) begin
         prev_seq[s] = '0;
         for (int i = 0; i < SLOTS; i++) begin
            held_vld[s][i] = 1'b0;
            held_stamp[s][i] = '0;
            held_seq[s][i] = '0;
         end
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_word = '0;
      typed_valid = 1'b0;
      typed_rsp = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      for (int i = 0; i < NUM_CASES; i++)
         send_frame(FRAME_CASES[i].frame, FRAME_CASES[i].typed, FRAME_CASES[i].result);
      // fill the right table past the reset limit, then to full depth
      run_phase(1'b0, '0, 300, 0, 0, SIDE_RIGHT, 0);
      run_phase(1'b1, 9'd511, 30, 69, 0, SIDE_RIGHT, 0);
      // drop the limit while the table is full
      run_phase(1'b1, 9'd2, 40, 0, 69, SIDE_ANY, 50);
      run_phase(1'b1, 9'd0, 50, 20, 20, SIDE_ANY, 30);
      run_phase(1'b1, 9'd1, 50, 0, 0, SIDE_ANY, 30);
      run_phase(1'b1, 9'd256, 30, 69, 0, SIDE_ANY, 30);
      run_phase(1'b1, 9'd3, 40, 0, 69, SIDE_ANY, 40);
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("stereo_exact_timestamp_pairer_unit regression: pass");
      else
         $display("stereo_exact_timestamp_pairer_unit regression: fail");
      $finish;
   end

endmodule
